>>> rtl/core/wcl_pkg.sv
package wcl_pkg;

	typedef enum logic [1:0] {
		CMD_STORE    = 2'd0,
		CMD_ACTIVATE = 2'd1,
		CMD_LOOKUP   = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [63:0] week_key;
		logic [31:0]        time_ms;
		logic [7:0]         event_count;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] slot_index;
		logic       fresh;
		logic [6:0] stored_count;
		logic [3:0] valid_slots;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic ld;
		logic rd;
		logic cmp;
		logic adv;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic last_slot;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/wcl_ctrl.sv
module wcl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output wcl_pkg::ctl_t ctl,
	input  wcl_pkg::sts_t sts
);
	import wcl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_RD;
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = sts.last_slot ? S_FIN : S_RD;
			end
			S_FIN: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				ctl.ld    = req_valid;
			end
			S_RD: begin
				ctl.rd = 1'b1;
			end
			S_CMP: begin
				ctl.cmp = 1'b1;
				ctl.adv = !sts.last_slot;
			end
			S_FIN: begin
				ctl.fin = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	a_fin_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> sts.out_free)
		else $error("commit while result register is occupied");
	a_cmp_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |=> ctl.cmp)
		else $error("slot read not followed by compare");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd || ctl.cmp || state_q == S_FIN) |-> !req_ready)
		else $error("request accepted while busy");

endmodule

>>> rtl/core/wcl_datapath.sv
module wcl_datapath #(
	parameter int SLOTS      = 8,
	parameter int MAX_EVENTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wcl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output wcl_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  wcl_pkg::ctl_t ctl,
	output wcl_pkg::sts_t sts
);
	import wcl_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [63:0] tag_mem [SLOTS];
	logic [31:0] ref_mem [SLOTS];
	logic [31:0] ser_mem [SLOTS];
	logic [6:0]  cnt_mem [SLOTS];

	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]    vcnt_q;
	logic [31:0]      serial_q;
	logic [31:0]      max_age_q;

	req_t        req_q;
	logic [IW-1:0] scan_idx_q;
	logic [63:0] rd_tag_q;
	logic [31:0] rd_ref_q;
	logic [31:0] rd_ser_q;
	logic [6:0]  rd_cnt_q;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [31:0]   hit_ref_q;
	logic [6:0]    hit_cnt_q;
	logic          inv_found_q;
	logic [IW-1:0] inv_idx_q;
	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_ser_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic          is_store;
	logic          is_act;
	logic          is_hit_cmd;
	logic [IW-1:0] wr_idx;
	logic [7:0]    sat_cnt;
	logic [31:0]   serial_nx;
	logic [31:0]   age;
	logic          commit;
	logic          slot_hit;
	logic          new_slot;

	assign is_store   = (req_q.cmd == CMD_STORE);
	assign is_hit_cmd = (req_q.cmd inside {CMD_ACTIVATE, CMD_LOOKUP}) && hit_q;
	assign is_act     = (req_q.cmd == CMD_ACTIVATE) && hit_q;
	assign wr_idx     = hit_q ? hit_idx_q : (inv_found_q ? inv_idx_q : best_idx_q);
	assign sat_cnt    = (req_q.event_count > 8'(MAX_EVENTS)) ? 8'(MAX_EVENTS)
	                                                         : req_q.event_count;
	assign serial_nx  = serial_q + 32'd1;
	assign age        = req_q.time_ms - hit_ref_q;
	assign commit     = ctl.fin;
	assign slot_hit   = valid_q[scan_idx_q] && (rd_tag_q == req_q.week_key);
	assign new_slot   = is_store && !valid_q[wr_idx];

	assign sts.last_slot = (scan_idx_q == IW'(SLOTS - 1));
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= '0;
		end else if (cfg_we) begin
			max_age_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			req_q <= req;
		end
		if (ctl.rd) begin
			rd_tag_q <= tag_mem[scan_idx_q];
			rd_ref_q <= ref_mem[scan_idx_q];
			rd_ser_q <= ser_mem[scan_idx_q];
			rd_cnt_q <= cnt_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (commit && is_store) begin
			tag_mem[wr_idx] <= req_q.week_key;
			ref_mem[wr_idx] <= req_q.time_ms;
			cnt_mem[wr_idx] <= 7'(sat_cnt);
		end
		if (commit && (is_store || is_act)) begin
			ser_mem[wr_idx] <= serial_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
		end else if (ctl.ld) begin
			scan_idx_q  <= '0;
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
		end else if (ctl.cmp) begin
			if (ctl.adv) scan_idx_q <= scan_idx_q + 1'b1;
			if (slot_hit && !hit_q) hit_q <= 1'b1;
			if (!valid_q[scan_idx_q] && !inv_found_q) inv_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			if (slot_hit && !hit_q) begin
				hit_idx_q <= scan_idx_q;
				hit_ref_q <= rd_ref_q;
				hit_cnt_q <= rd_cnt_q;
			end
			if (!valid_q[scan_idx_q] && !inv_found_q) begin
				inv_idx_q <= scan_idx_q;
			end
			if ((scan_idx_q == '0) || (rd_ser_q < best_ser_q)) begin
				best_idx_q <= scan_idx_q;
				best_ser_q <= rd_ser_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vcnt_q   <= '0;
			serial_q <= '0;
		end else if (commit) begin
			if (is_store) valid_q[wr_idx] <= 1'b1;
			if (new_slot) vcnt_q <= vcnt_q + 1'b1;
			if (is_store || is_act) serial_q <= serial_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.ok           <= is_store || is_hit_cmd;
			rsp_q.slot_index   <= (is_store || is_hit_cmd) ? 3'(wr_idx) : 3'd0;
			rsp_q.fresh        <= (req_q.cmd == CMD_LOOKUP) && hit_q && (age < max_age_q);
			rsp_q.stored_count <= is_store ? 7'(sat_cnt) : (is_hit_cmd ? hit_cnt_q : 7'd0);
			rsp_q.valid_slots  <= new_slot ? 4'(vcnt_q + 1'b1) : 4'(vcnt_q);
		end
	end

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q == CW'($countones(valid_q)))
		else $error("valid slot count out of step with valid bits");
	a_store_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_store) |=> valid_q[$past(wr_idx)])
		else $error("stored slot not marked valid");
	a_serial_step: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (is_store || is_act)) |=> serial_q == $past(serial_q) + 32'd1)
		else $error("access serial did not advance by one");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.ok) |-> (rsp_q.slot_index == 3'd0 &&
		rsp_q.stored_count == 7'd0 && !rsp_q.fresh))
		else $error("miss result carries slot data");

endmodule

>>> rtl/core/week_cache_lru_tag_store.sv
// Fully associative week tag store with least-recently-used replacement. Each
// request is one transfer on req and yields one transfer on rsp; the store
// works on one request at a time and takes the next only after the commit and the
// walk over the slot memories before it, which reads each slot in a read state and
// then compares it in a compare state. The result waits in an output register,
// so a stalled rsp only holds the store in its final commit state.
// Store reuses the matching slot, else the lowest free slot, else the slot with
// the smallest access serial; max_age may be written only while the store is idle.
module week_cache_lru_tag_store #(
	parameter int SLOTS      = 8,
	parameter int MAX_EVENTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  wcl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output wcl_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);
	import wcl_pkg::*;

	ctl_t ctl;
	sts_t sts;

	wcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	wcl_datapath #(
		.SLOTS      (SLOTS),
		.MAX_EVENTS (MAX_EVENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

>>> tb/week_cache_lru_tag_store_tb.sv
`timescale 1ns / 1ps

module week_cache_lru_tag_store_tb;
	import wcl_pkg::*;

	localparam int SLOTS      = 8;
	localparam int MAX_EVENTS = 64;
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 84;
	localparam int POOL       = 10;

	localparam logic [63:0] KEY_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	class lru_slot_tracker;
		rsp_t        expected_rsp_q[$];
		logic [31:0] max_age;
		bit          slot_valid[SLOTS];
		logic [63:0] slot_tag[SLOTS];
		logic [31:0] slot_time[SLOTS];
		logic [31:0] slot_serial[SLOTS];
		logic [6:0]  slot_count[SLOTS];
		logic [31:0] serial_ctr;
		int          fails;

		function void clear();
			max_age = '0;
			serial_ctr = '0;
			fails = 0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				slot_tag[i] = '0;
				slot_time[i] = '0;
				slot_serial[i] = '0;
				slot_count[i] = '0;
			end
		endfunction

		function int pending();
			return expected_rsp_q.size();
		endfunction

		function void note_request(req_t r);
			rsp_t       e;
			int         hit;
			int         s;
			int         n;
			logic [6:0] cnt;
			e = '0;
			hit = -1;
			s = -1;
			n = 0;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (slot_valid[i] && slot_tag[i] == r.week_key)
					hit = i;
			case (cmd_t'(r.cmd))
				CMD_STORE: begin
					s = hit;
					if (s < 0)
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!slot_valid[i])
								s = i;
					if (s < 0) begin
						s = 0;
						for (int i = 1; i < SLOTS; i++)
							if (slot_serial[i] < slot_serial[s])
								s = i;
					end
					cnt = (r.event_count > MAX_EVENTS) ? 7'(MAX_EVENTS) : r.event_count[6:0];
					serial_ctr = serial_ctr + 32'd1;
					slot_valid[s] = 1'b1;
					slot_tag[s] = r.week_key;
					slot_time[s] = r.time_ms;
					slot_serial[s] = serial_ctr;
					slot_count[s] = cnt;
					e.ok = 1'b1;
					e.slot_index = 3'(s);
					e.stored_count = cnt;
				end
				CMD_ACTIVATE, CMD_LOOKUP: begin
					if (hit >= 0) begin
						e.ok = 1'b1;
						e.slot_index = 3'(hit);
						e.stored_count = slot_count[hit];
						if (cmd_t'(r.cmd) == CMD_ACTIVATE) begin
							serial_ctr = serial_ctr + 32'd1;
							slot_serial[hit] = serial_ctr;
						end else begin
							e.fresh = ((r.time_ms - slot_time[hit]) < max_age);
						end
					end
				end
				default: ;
			endcase
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i])
					n++;
			e.valid_slots = 4'(n);
			expected_rsp_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_rsp_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected response %p", got);
				return;
			end
			e = expected_rsp_q.pop_front();
			if (got.ok !== e.ok || got.slot_index !== e.slot_index || got.fresh !== e.fresh ||
			    got.stored_count !== e.stored_count || got.valid_slots !== e.valid_slots) begin
				fails++;
				if (fails <= 10)
					$display("response mismatch: expected %p, actual %p", e, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	lru_slot_tracker tracker;
	bit              steady;
	logic [63:0]     key_pool[POOL];
	logic [31:0]     now_ms;

	week_cache_lru_tag_store #(
		.SLOTS(SLOTS),
		.MAX_EVENTS(MAX_EVENTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function req_t make_item();
		req_t r;
		int   roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			r.cmd = CMD_STORE;
		else if (roll < 65)
			r.cmd = CMD_ACTIVATE;
		else if (roll < 95)
			r.cmd = CMD_LOOKUP;
		else
			r.cmd = CMD_UNUSED;
		if ($urandom_range(0, 99) < 85)
			r.week_key = key_pool[$urandom_range(0, POOL - 1)];
		else
			r.week_key = {$urandom, $urandom};
		now_ms = now_ms + 32'($urandom_range(0, 25));
		r.time_ms = ($urandom_range(0, 99) < 90) ? now_ms : $urandom;
		r.event_count = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 80))
		                                             : 8'($urandom_range(0, 255));
		return r;
	endfunction

	task send_req(req_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		tracker.note_request(r);
	endtask

	task send_op(cmd_t c, logic [63:0] k, logic [31:0] t, logic [7:0] n);
		req_t r;
		r.cmd = c;
		r.week_key = k;
		r.time_ms = t;
		r.event_count = n;
		send_req(r);
	endtask

	task set_max_age(logic [31:0] v);
		@(negedge clk);
		req_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.max_age = v;
	endtask

	initial begin
		int          spin;
		logic [31:0] ages[PHASES];
		tracker = new;
		tracker.clear();
		steady = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		set_max_age(32'd100);
		send_op(CMD_LOOKUP, 64'd0, 32'd0, 8'd0);
		send_op(CMD_ACTIVATE, KEY_MIN, 32'd0, 8'd0);
		send_op(CMD_STORE, KEY_MIN, 32'd0, 8'd255);
		send_op(CMD_STORE, KEY_MAX, 32'hFFFF_FFFF, 8'd0);
		send_op(CMD_STORE, 64'd0, 32'd10, 8'd64);
		send_op(CMD_STORE, KEY_ONES, 32'd20, 8'd65);
		send_op(CMD_STORE, 64'd1, 32'd30, 8'd63);
		send_op(CMD_STORE, 64'd2, 32'd30, 8'd128);
		send_op(CMD_STORE, 64'd3, 32'd30, 8'd200);
		send_op(CMD_STORE, 64'd4, 32'd30, 8'd7);
		send_op(CMD_LOOKUP, KEY_MIN, 32'd99, 8'd0);
		send_op(CMD_LOOKUP, KEY_MIN, 32'd100, 8'd0);
		send_op(CMD_LOOKUP, KEY_MAX, 32'd98, 8'd0);
		send_op(CMD_ACTIVATE, KEY_MIN, 32'd0, 8'd0);
		send_op(CMD_STORE, 64'd5, 32'd35, 8'd1);
		send_op(CMD_STORE, 64'd0, 32'd40, 8'd10);
		send_op(CMD_UNUSED, KEY_MIN, 32'hFFFF_FFFF, 8'hFF);
		send_op(CMD_LOOKUP, KEY_MAX, 32'd50, 8'd0);
		send_op(CMD_ACTIVATE, 64'd0, 32'd0, 8'd0);
		set_max_age(32'hFFFF_FFFF);
		send_op(CMD_LOOKUP, KEY_MIN, 32'hFFFF_FFFF, 8'd0);
		send_op(CMD_LOOKUP, KEY_MIN, 32'hFFFF_FFFE, 8'd0);
		set_max_age(32'd0);
		send_op(CMD_LOOKUP, 64'd0, 32'd40, 8'd0);

		ages = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd50, 32'd500, $urandom};
		for (int p = 0; p < PHASES; p++) begin
			set_max_age(ages[p]);
			steady = (p == 2);
			for (int i = 0; i < POOL; i++)
				key_pool[i] = {$urandom, $urandom};
			now_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_req(make_item());
		end

		@(negedge clk);
		req_valid <= 1'b0;
		spin = 0;
		while (tracker.pending() != 0 && spin < 100000) begin
			@(posedge clk);
			spin++;
		end
		repeat (2 * SLOTS + 4) @(posedge clk);
		if (tracker.pending() == 0 && tracker.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int hold;
		hold = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
